[hw/rtl/ctet_pkg.sv]
// ----------------------------------------------------------------------------
// ctet_pkg
// Shared types and constants for the current trend energy tally.
// ----------------------------------------------------------------------------
package ctet_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CurW    = 16;
  localparam int unsigned PwrW    = 20;
  localparam int unsigned EnergyW = 48;
  localparam int unsigned ProdW   = PwrW + TimeW;
  localparam int unsigned CountW  = 16;

  typedef enum logic [1:0] {
    CLS_UNLOAD = 2'd0,
    CLS_LOAD   = 2'd1,
    CLS_IDLE   = 2'd2
  } cls_e;

  // Word handed from the front stage to the accumulate stage.
  typedef struct packed {
    cls_e              cls;
    logic [TimeW-1:0]  sample_time;
    logic              last;
    logic              batch_start;
    logic [ProdW-1:0]  energy;
  } stage_t;

endpackage

[hw/rtl/ctet_front.sv]
// ----------------------------------------------------------------------------
// ctet_front
// Input register: classes each word against the previous current and forms
// previous power times time step.
// ----------------------------------------------------------------------------
module ctet_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ctet_pkg::TimeW-1:0]      sample_time_i,
  input  logic [ctet_pkg::CurW-1:0]       current_sample_i,
  input  logic [ctet_pkg::PwrW-1:0]       power_sample_i,
  input  logic                            last_of_batch_i,
  input  logic                            adv_i,
  output logic                            s1_valid_o,
  output ctet_pkg::stage_t                s1_o
);

  logic                        s1_valid_q;
  ctet_pkg::stage_t            s1_q;
  logic [ctet_pkg::TimeW-1:0]  last_time_q;
  logic [ctet_pkg::PwrW-1:0]   last_power_q;
  logic [ctet_pkg::CurW-1:0]   last_cur_q;
  logic                        have_prev_q;
  logic                        start_q;
  logic                        accept;
  logic [ctet_pkg::TimeW-1:0]  dt;
  ctet_pkg::cls_e              cls;

  assign in_stall_o = s1_valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign dt         = sample_time_i - last_time_q;

  always_comb begin
    if (start_q && !have_prev_q) begin
      cls = ctet_pkg::CLS_IDLE;
    end else if (current_sample_i > last_cur_q) begin
      cls = ctet_pkg::CLS_LOAD;
    end else if (current_sample_i < last_cur_q) begin
      cls = ctet_pkg::CLS_UNLOAD;
    end else begin
      cls = ctet_pkg::CLS_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      last_time_q  <= '0;
      last_power_q <= '0;
      last_cur_q   <= '0;
      have_prev_q  <= 1'b0;
      start_q      <= 1'b1;
    end else begin
      if (!s1_valid_q || adv_i) begin
        s1_valid_q <= in_valid_i;
      end
      if (accept) begin
        last_time_q  <= sample_time_i;
        last_power_q <= power_sample_i;
        last_cur_q   <= current_sample_i;
        start_q      <= last_of_batch_i;
        if (last_of_batch_i) begin
          have_prev_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.cls         <= cls;
      s1_q.sample_time <= sample_time_i;
      s1_q.last        <= last_of_batch_i;
      s1_q.batch_start <= start_q;
      s1_q.energy      <= ctet_pkg::ProdW'(last_power_q) * ctet_pkg::ProdW'(dt);
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

[hw/rtl/ctet_accum.sv]
// ----------------------------------------------------------------------------
// ctet_accum
// Segment tracking and saturating totals; its registers are the result word.
// ----------------------------------------------------------------------------
module ctet_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  ctet_pkg::stage_t                  s1_i,
  output logic [1:0]                        trend_class_o,
  output logic [ctet_pkg::EnergyW-1:0]      load_energy_o,
  output logic [ctet_pkg::EnergyW-1:0]      unload_energy_o,
  output logic [ctet_pkg::TimeW-1:0]        load_seconds_o,
  output logic [ctet_pkg::TimeW-1:0]        unload_seconds_o,
  output logic [ctet_pkg::CountW-1:0]       load_segments_o,
  output logic [ctet_pkg::CountW-1:0]       unload_segments_o
);

  localparam logic [ctet_pkg::EnergyW-1:0] EMax = '1;
  localparam logic [ctet_pkg::TimeW-1:0]   TMax = '1;
  localparam logic [ctet_pkg::CountW-1:0]  CMax = '1;

  ctet_pkg::cls_e                 cls_q, prev_q;
  logic [ctet_pkg::TimeW-1:0]     seg_q, seg_d;
  logic [ctet_pkg::EnergyW-1:0]   le_q, le_d, ue_q, ue_d;
  logic [ctet_pkg::TimeW-1:0]     lt_q, lt_d, ut_q, ut_d;
  logic [ctet_pkg::CountW-1:0]    lc_q, lc_d, uc_q, uc_d;
  logic [ctet_pkg::ProdW:0]       e_sum;
  logic [ctet_pkg::EnergyW-1:0]   e_base, e_sat;
  logic [ctet_pkg::TimeW-1:0]     seg_dt, t_base, t_sat;
  logic [ctet_pkg::TimeW:0]       t_sum;
  logic                           mid, l_time, u_time, l_cnt, u_cnt;

  assign mid    = !s1_i.batch_start;
  assign seg_dt = s1_i.sample_time - seg_q;

  // energy total: at most one of the two moves per word
  assign e_base = (s1_i.cls == ctet_pkg::CLS_LOAD) ? le_q : ue_q;
  assign e_sum  = (ctet_pkg::ProdW + 1)'(e_base) + (ctet_pkg::ProdW + 1)'(s1_i.energy);
  assign e_sat  = (e_sum > (ctet_pkg::ProdW + 1)'(EMax)) ? EMax
                                                        : e_sum[ctet_pkg::EnergyW-1:0];

  // segment close adds time and a count; the batch end adds time only
  assign l_cnt  = mid && prev_q == ctet_pkg::CLS_LOAD && s1_i.cls != ctet_pkg::CLS_LOAD;
  assign u_cnt  = mid && prev_q == ctet_pkg::CLS_UNLOAD && s1_i.cls != ctet_pkg::CLS_UNLOAD;
  assign l_time = l_cnt || (mid && s1_i.last && prev_q == ctet_pkg::CLS_LOAD);
  assign u_time = u_cnt || (mid && s1_i.last && prev_q == ctet_pkg::CLS_UNLOAD);

  assign t_base = l_time ? lt_q : ut_q;
  assign t_sum  = (ctet_pkg::TimeW + 1)'(t_base) + (ctet_pkg::TimeW + 1)'(seg_dt);
  assign t_sat  = t_sum[ctet_pkg::TimeW] ? TMax : t_sum[ctet_pkg::TimeW-1:0];

  always_comb begin
    le_d  = le_q;
    ue_d  = ue_q;
    lt_d  = lt_q;
    ut_d  = ut_q;
    lc_d  = lc_q;
    uc_d  = uc_q;
    seg_d = seg_q;
    if (mid && s1_i.cls == ctet_pkg::CLS_LOAD) begin
      le_d = e_sat;
    end
    if (mid && s1_i.cls == ctet_pkg::CLS_UNLOAD) begin
      ue_d = e_sat;
    end
    if (l_time) begin
      lt_d = t_sat;
    end
    if (u_time) begin
      ut_d = t_sat;
    end
    if (l_cnt && lc_q != CMax) begin
      lc_d = lc_q + 1'b1;
    end
    if (u_cnt && uc_q != CMax) begin
      uc_d = uc_q + 1'b1;
    end
    if (!mid || s1_i.cls != prev_q) begin
      seg_d = s1_i.sample_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q  <= ctet_pkg::CLS_IDLE;
      prev_q <= ctet_pkg::CLS_IDLE;
      seg_q  <= '0;
      le_q   <= '0;
      ue_q   <= '0;
      lt_q   <= '0;
      ut_q   <= '0;
      lc_q   <= '0;
      uc_q   <= '0;
    end else if (take_i) begin
      cls_q  <= s1_i.cls;
      prev_q <= s1_i.cls;
      seg_q  <= seg_d;
      le_q   <= le_d;
      ue_q   <= ue_d;
      lt_q   <= lt_d;
      ut_q   <= ut_d;
      lc_q   <= lc_d;
      uc_q   <= uc_d;
    end
  end

  assign trend_class_o     = cls_q;
  assign load_energy_o     = le_q;
  assign unload_energy_o   = ue_q;
  assign load_seconds_o    = lt_q;
  assign unload_seconds_o  = ut_q;
  assign load_segments_o   = lc_q;
  assign unload_segments_o = uc_q;

endmodule

[hw/rtl/current_trend_energy_tally.sv]
// ----------------------------------------------------------------------------
// current_trend_energy_tally
// Classes current samples as load, unload or idle and keeps saturating
// energy, segment time and segment count totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one sample word; a word is
//   taken on a clock edge with valid high and stall low. last_of_batch_i
//   marks the final sample of a batch.
//   Output channel out_valid_o / out_stall_i returns one result word per
//   sample, with the totals after that sample.
//   The first register holds the sample with its class and the power-time
//   product (one 20x32 multiply); the second applies the saturating
//   accumulates and raises out_valid_o.
//   Throughput: one word per cycle for as long as the receiver takes words.
//   When out_stall_i is high the result holds and one more sample can wait
//   in the first register; after that in_stall_o rises.
//   Reset clears all totals, empties both registers and starts a new batch
//   with no earlier batch; there is no clearing pass.
// ----------------------------------------------------------------------------
module current_trend_energy_tally (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ctet_pkg::TimeW-1:0]        sample_time_i,
  input  logic [ctet_pkg::CurW-1:0]         current_sample_i,
  input  logic [ctet_pkg::PwrW-1:0]         power_sample_i,
  input  logic                              last_of_batch_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        trend_class_o,
  output logic [ctet_pkg::EnergyW-1:0]      load_energy_o,
  output logic [ctet_pkg::EnergyW-1:0]      unload_energy_o,
  output logic [ctet_pkg::TimeW-1:0]        load_seconds_o,
  output logic [ctet_pkg::TimeW-1:0]        unload_seconds_o,
  output logic [ctet_pkg::CountW-1:0]       load_segments_o,
  output logic [ctet_pkg::CountW-1:0]       unload_segments_o
);

  logic             out_valid_q;
  logic             adv;
  logic             s1_valid;
  ctet_pkg::stage_t s1;

  assign adv = !out_valid_q || !out_stall_i;

  ctet_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_time_i    (sample_time_i),
    .current_sample_i (current_sample_i),
    .power_sample_i   (power_sample_i),
    .last_of_batch_i  (last_of_batch_i),
    .adv_i            (adv),
    .s1_valid_o       (s1_valid),
    .s1_o             (s1)
  );

  ctet_accum u_accum (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .take_i            (s1_valid && adv),
    .s1_i              (s1),
    .trend_class_o     (trend_class_o),
    .load_energy_o     (load_energy_o),
    .unload_energy_o   (unload_energy_o),
    .load_seconds_o    (load_seconds_o),
    .unload_seconds_o  (unload_seconds_o),
    .load_segments_o   (load_segments_o),
    .unload_segments_o (unload_segments_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid;
    end
  end

  assign out_valid_o = out_valid_q;

  // input backs up only when both registers are full and the output is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && out_valid_o && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_energy_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (load_energy_o >= $past(load_energy_o)) &&
             (unload_energy_o >= $past(unload_energy_o)))
    else $error("energy total decreased");

  a_totals_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid && adv) |=> $stable(load_seconds_o) && $stable(unload_segments_o))
    else $error("totals moved without a word");

  a_count_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (load_segments_o == $past(load_segments_o)) ||
             (load_seconds_o >= $past(load_seconds_o)))
    else $error("load segment counted while time total fell");

endmodule

[sim/current_trend_energy_tally_tb.sv]
// ----------------------------------------------------------------------------
// current_trend_energy_tally_tb
// Drives sample words into the trend tally with random gaps and output stalls.
// Each accepted word is run through a local model of the classing and the
// saturating totals. Every result word is checked field by field against it.
// The run covers directed corner cases, random batches and a short
// alternating run at full rate that closes a segment on every word but the
// first of each batch. It ends with wrapped timestamps that saturate the
// energy and time totals.
module current_trend_energy_tally_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [19:0] PwrMax = '1;
  localparam int unsigned ShowLimit = 40;

  typedef struct {
    logic [31:0] stamp;
    logic [15:0] amps;
    logic [19:0] watts;
    logic        closes;
  } sample_t;

  typedef struct {
    ctet_pkg::cls_e cls;
    logic [47:0]    load_e;
    logic [47:0]    unload_e;
    logic [31:0]    load_s;
    logic [31:0]    unload_s;
    logic [15:0]    load_n;
    logic [15:0]    unload_n;
  } tally_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] sample_time_i = '0;
  logic [15:0] current_sample_i = '0;
  logic [19:0] power_sample_i = '0;
  logic        last_of_batch_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  trend_class_o;
  logic [47:0] load_energy_o;
  logic [47:0] unload_energy_o;
  logic [31:0] load_seconds_o;
  logic [31:0] unload_seconds_o;
  logic [15:0] load_segments_o;
  logic [15:0] unload_segments_o;

  current_trend_energy_tally DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_time_i     (sample_time_i),
    .current_sample_i  (current_sample_i),
    .power_sample_i    (power_sample_i),
    .last_of_batch_i   (last_of_batch_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .trend_class_o     (trend_class_o),
    .load_energy_o     (load_energy_o),
    .unload_energy_o   (unload_energy_o),
    .load_seconds_o    (load_seconds_o),
    .unload_seconds_o  (unload_seconds_o),
    .load_segments_o   (load_segments_o),
    .unload_segments_o (unload_segments_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sample_t     sample_q[$];
  tally_t      tally_q[$];
  int unsigned pushed_total = 0;
  int unsigned taken_total = 0;
  int unsigned result_idx = 0;
  int unsigned fail_count = 0;
  bit          word_taken = 1'b0;
  bit          rush = 1'b0;
  int          in_gap = 0;
  int          in_calm = 0;
  int          hold_left = 0;
  int          out_calm = 0;

  // model state
  logic [15:0]    last_amps = '0;
  logic [19:0]    last_watts = '0;
  logic [31:0]    last_stamp = '0;
  ctet_pkg::cls_e last_cls = ctet_pkg::CLS_IDLE;
  logic [31:0]    seg_start = '0;
  bit             seen_batch = 1'b0;
  bit             batch_fresh = 1'b1;
  tally_t         totals = '{cls: ctet_pkg::CLS_IDLE, default: '0};

  function automatic ctet_pkg::cls_e trend_of(logic [15:0] now_a, logic [15:0] was_a);
    if (now_a > was_a) return ctet_pkg::CLS_LOAD;
    if (now_a < was_a) return ctet_pkg::CLS_UNLOAD;
    return ctet_pkg::CLS_IDLE;
  endfunction

  function automatic logic [47:0] sat_energy(logic [47:0] acc, logic [51:0] add);
    logic [52:0] sum;
    sum = {5'b0, acc} + {1'b0, add};
    return (sum > 53'hFFFF_FFFF_FFFF) ? '1 : sum[47:0];
  endfunction

  function automatic logic [31:0] sat_secs(logic [31:0] acc, logic [31:0] add);
    logic [32:0] sum;
    sum = {1'b0, acc} + {1'b0, add};
    return sum[32] ? '1 : sum[31:0];
  endfunction

  function automatic logic [15:0] sat_bump(logic [15:0] n);
    return (n == 16'hFFFF) ? n : n + 16'd1;
  endfunction

  function automatic void add_seconds(ctet_pkg::cls_e c, logic [31:0] span);
    if (c == ctet_pkg::CLS_LOAD) totals.load_s = sat_secs(totals.load_s, span);
    else if (c == ctet_pkg::CLS_UNLOAD) totals.unload_s = sat_secs(totals.unload_s, span);
  endfunction

  function automatic tally_t advance_tally(sample_t s);
    ctet_pkg::cls_e c;
    logic [31:0]    dt;
    logic [51:0]    e;
    if (batch_fresh) begin
      c = seen_batch ? trend_of(s.amps, last_amps) : ctet_pkg::CLS_IDLE;
      seg_start = s.stamp;
    end else begin
      dt = s.stamp - last_stamp;
      e = 52'(last_watts) * 52'(dt);
      c = trend_of(s.amps, last_amps);
      if (c == ctet_pkg::CLS_LOAD) totals.load_e = sat_energy(totals.load_e, e);
      else if (c == ctet_pkg::CLS_UNLOAD) totals.unload_e = sat_energy(totals.unload_e, e);
      if (c != last_cls) begin
        if (last_cls == ctet_pkg::CLS_LOAD) begin
          add_seconds(ctet_pkg::CLS_LOAD, s.stamp - seg_start);
          totals.load_n = sat_bump(totals.load_n);
        end else if (last_cls == ctet_pkg::CLS_UNLOAD) begin
          add_seconds(ctet_pkg::CLS_UNLOAD, s.stamp - seg_start);
          totals.unload_n = sat_bump(totals.unload_n);
        end
        seg_start = s.stamp;
      end
    end
    if (s.closes) begin
      if (seg_start != s.stamp) add_seconds(c, s.stamp - seg_start);
      seen_batch = 1'b1;
      batch_fresh = 1'b1;
    end else begin
      batch_fresh = 1'b0;
    end
    last_amps = s.amps;
    last_watts = s.watts;
    last_stamp = s.stamp;
    last_cls = c;
    totals.cls = c;
    return totals;
  endfunction

  function automatic int pause_len(inout int calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_fail(string msg);
    if (fail_count < ShowLimit) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      note_fail($sformatf("word %0d %s got %0h want %0h", result_idx, name, got, want));
  endtask

  task automatic push_sample(logic [31:0] t, logic [15:0] c, logic [19:0] p, logic last);
    sample_q.push_back('{stamp: t, amps: c, watts: p, closes: last});
    pushed_total++;
  endtask

  // input side: words change on the falling edge
  always @(negedge clk_i) begin
    sample_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_taken) begin
      // stalled word holds
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid_i <= 1'b0;
    end else if (sample_q.size() > 0) begin
      nxt = sample_q.pop_front();
      sample_time_i <= nxt.stamp;
      current_sample_i <= nxt.amps;
      power_sample_i <= nxt.watts;
      last_of_batch_i <= nxt.closes;
      in_valid_i <= 1'b1;
      in_gap = rush ? 0 : pause_len(in_calm);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // output side stall pattern
  always @(negedge clk_i) begin
    if (rush || !rst_ni) begin
      hold_left = 0;
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      hold_left = pause_len(out_calm);
      out_stall_i <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk_i) begin
    tally_t  want;
    sample_t s;
    word_taken = rst_ni && in_valid_i && !in_stall_o;
    if (word_taken) begin
      s = '{stamp: sample_time_i, amps: current_sample_i, watts: power_sample_i,
            closes: last_of_batch_i};
      tally_q.push_back(advance_tally(s));
      taken_total++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tally_q.size() == 0) begin
        note_fail($sformatf("word %0d arrived with no sample pending", result_idx));
      end else begin
        want = tally_q.pop_front();
        check_field("trend_class", 64'(trend_class_o), 64'(want.cls));
        check_field("load_energy", 64'(load_energy_o), 64'(want.load_e));
        check_field("unload_energy", 64'(unload_energy_o), 64'(want.unload_e));
        check_field("load_seconds", 64'(load_seconds_o), 64'(want.load_s));
        check_field("unload_seconds", 64'(unload_seconds_o), 64'(want.unload_s));
        check_field("load_segments", 64'(load_segments_o), 64'(want.load_n));
        check_field("unload_segments", 64'(unload_segments_o), 64'(want.unload_n));
      end
      result_idx++;
    end
  end

  task automatic push_random_batches(int unsigned target);
    int unsigned made;
    int unsigned len;
    int unsigned r;
    logic [31:0] t;
    logic [15:0] c;
    logic [19:0] p;
    made = 0;
    c = 16'($urandom);
    while (made < target) begin
      r = $urandom_range(99);
      len = (r < 10) ? 1 : (r < 85) ? $urandom_range(2, 8) : $urandom_range(9, 40);
      t = $urandom;
      for (int k = 0; k < len; k++) begin
        if (k > 0) begin
          r = $urandom_range(99);
          if (r >= 20) t += (r < 90) ? $urandom_range(1, 10) : $urandom_range(11, 1000);
        end
        r = $urandom_range(99);
        if (r < 5) c = '0;
        else if (r < 10) c = '1;
        else if (r < 25) c = 16'($urandom);
        else if (r < 55) c = c + 16'($urandom_range(1, 300));
        else if (r < 80) c = c - 16'($urandom_range(1, 300));
        r = $urandom_range(99);
        p = (r < 15) ? '0 : (r < 25) ? PwrMax : (r < 40) ? 20'($urandom_range(0, 50))
                                                          : 20'($urandom);
        push_sample(t, c, p, k == len - 1);
      end
      made += len;
    end
  endtask

  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] t;

    // first batch after reset, no earlier batch
    push_sample(32'd0, 16'd0, 20'd0, 1'b0);
    push_sample(32'd3, 16'd0, PwrMax, 1'b0);
    push_sample(32'd5, 16'hFFFF, PwrMax, 1'b0);
    push_sample(32'd9, 16'hFFFF, 20'd7, 1'b0);
    push_sample(32'd10, 16'd100, 20'd1, 1'b0);
    push_sample(32'd12, 16'd50, 20'd1, 1'b0);
    push_sample(32'd15, 16'd20, 20'd3, 1'b1);
    // batch start classed against last batch, timestamp wraps forward
    push_sample(32'hFFFF_FFFF, 16'd30, 20'd9, 1'b0);
    push_sample(32'd2, 16'd40, 20'd5, 1'b0);
    push_sample(32'd4, 16'd10, 20'd5, 1'b0);
    push_sample(32'd4, 16'd0, 20'd5, 1'b1);
    // single-sample batches
    push_sample(32'd1000, 16'd0, 20'd2, 1'b1);
    push_sample(32'd2000, 16'hFFFF, 20'd2, 1'b1);
    push_sample(32'd3000, 16'd0, 20'd2, 1'b1);
    // back-to-back segment closes
    push_sample(32'h8000_0000, 16'd0, PwrMax, 1'b0);
    push_sample(32'h8000_0001, 16'd1, PwrMax, 1'b0);
    push_sample(32'h8000_0002, 16'd0, PwrMax, 1'b0);
    push_sample(32'h8000_0003, 16'd1, PwrMax, 1'b0);
    push_sample(32'h8000_0004, 16'd1, PwrMax, 1'b1);
    push_sample(32'h5555_5555, 16'hAAAA, 20'hAAAAA, 1'b0);
    push_sample(32'h5555_555A, 16'h5555, 20'h55555, 1'b1);

    push_random_batches(1600);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // alternating run at full rate, a segment closes on every word but each batch's first
    wait (taken_total == pushed_total);
    rush = 1'b1;
    for (int b = 0; b < 4; b++) begin
      lo = 16'($urandom_range(0, 30000));
      hi = lo + 16'($urandom_range(1, 30000));
      t = $urandom;
      for (int k = 0; k < 40; k++)
        push_sample(t + 32'(k), k[0] ? hi : lo, 20'($urandom_range(0, 15)), k == 39);
    end
    wait (taken_total == pushed_total);
    rush = 1'b0;

    // time going backwards: energy and time totals saturate
    push_sample(32'd10, 16'd1, PwrMax, 1'b0);
    push_sample(32'd5, 16'd2, PwrMax, 1'b0);
    push_sample(32'd0, 16'd1, PwrMax, 1'b0);
    push_sample(32'd0, 16'd1, PwrMax, 1'b1);
    for (int k = 0; k < 60; k++)
      push_sample($urandom, 16'($urandom),
                  ($urandom_range(1) == 0) ? PwrMax : 20'($urandom),
                  $urandom_range(99) < 20);

    wait (taken_total == pushed_total);
    wait (tally_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[current_trend_energy_tally] OK");
    end else begin
      $display("[current_trend_energy_tally] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[current_trend_energy_tally] ERROR");
    $finish;
  end

endmodule

[files.f]
hw/rtl/ctet_pkg.sv
hw/rtl/ctet_front.sv
hw/rtl/ctet_accum.sv
hw/rtl/current_trend_energy_tally.sv
sim/current_trend_energy_tally_tb.sv
